/* hw/rtl/slot_allocator_free_stack_macros.svh */
// assertion macros for the slot allocator
// used by slot_allocator_free_stack, no other dependencies
`ifndef SLOT_ALLOCATOR_FREE_STACK_MACROS_SVH
`define SLOT_ALLOCATOR_FREE_STACK_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define SAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slot allocator check failed");
// next-cycle implication, checked out of reset
`define SAS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slot allocator check failed");
`else
`define SAS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SAS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/sas_pkg.sv */
// types and constants shared by the slot allocator files
// no dependencies
package sas_pkg;

    localparam int SLOTS        = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_W        = $clog2(SLOTS);
    localparam int CNT_W        = $clog2(SLOTS + 1);

    // request codes
    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_ADDED   = 2'd0;
    localparam logic [1:0] STAT_REMOVED = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    typedef struct packed {
        logic                    req_type;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [IDX_W-1:0]        slot_index;
    } t_req_item;

    typedef struct packed {
        logic [IDX_W-1:0]        assigned_index;
        logic [1:0]              status;
        logic [PAYLOAD_BITS-1:0] released_payload;
        logic [CNT_W-1:0]        live_count;
    } t_res_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

endpackage

/* hw/rtl/slot_allocator_free_stack.sv */
// flow: an accepted request item is latched, the update state reads the registered
//   slot and stack ram outputs and registers the result, held until it is taken
// items: one at a time; the next item is taken in the cycle its predecessor's
//   result leaves, and never while an item is in the update state
// reset: synchronous, clears the state, the counters and the occupancy bits;
//   ram contents stay undefined until written, no clearing pass
`include "slot_allocator_free_stack_macros.svh"

module slot_allocator_free_stack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_req_valid,
    output logic               o_req_stall,
    input  sas_pkg::t_req_item i_req,
    // result channel
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output sas_pkg::t_res_item o_res
);

    localparam int IDX_W = sas_pkg::IDX_W;
    localparam int CNT_W = sas_pkg::CNT_W;
    localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(sas_pkg::SLOTS);

    // control state
    sas_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_free_top, n_free_top;     // depth of the free stack
    logic [CNT_W-1:0] r_high_water, n_high_water; // slots ever taken from the top
    logic [CNT_W-1:0] r_occ_total, n_occ_total;   // live count
    logic [sas_pkg::SLOTS-1:0] r_occupied, n_occupied;

    // latched request and result register
    sas_pkg::t_req_item r_req;
    sas_pkg::t_res_item r_res, n_res;

    logic accept;
    logic take;

    // ram ports
    logic [sas_pkg::PAYLOAD_BITS-1:0] store_rdata;
    logic [IDX_W-1:0]                 stack_rdata;
    logic                             store_we;
    logic [IDX_W-1:0]                 store_waddr;
    logic                             stack_we;
    logic [IDX_W-1:0]                 stack_raddr;

    // decode in the update cycle
    logic             stack_nonempty;
    logic             add_got;
    logic [IDX_W-1:0] add_slot;
    logic             remove_ok;

    assign accept = i_req_valid && !o_req_stall;
    assign take   = (r_state == sas_pkg::ST_OUT) && !i_res_stall;

    // --------------------------------------------------------------------
    // state machine: next state
    // --------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sas_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = sas_pkg::ST_EXEC;
                end
            end
            sas_pkg::ST_EXEC: begin
                n_state = sas_pkg::ST_OUT;
            end
            sas_pkg::ST_OUT: begin
                if (take) begin
                    n_state = accept ? sas_pkg::ST_EXEC : sas_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sas_pkg::ST_IDLE;
            end
        endcase
    end

    // state machine: handshake outputs
    // a new item is let in while idle, or in the cycle the held result leaves
    always_comb begin
        o_req_stall = 1'b1;
        o_res_valid = 1'b0;
        unique case (r_state)
            sas_pkg::ST_IDLE: begin
                o_req_stall = 1'b0;
            end
            sas_pkg::ST_EXEC: begin
                o_req_stall = 1'b1;
            end
            sas_pkg::ST_OUT: begin
                o_res_valid = 1'b1;
                o_req_stall = i_res_stall;
            end
            default: begin
                o_req_stall = 1'b1;
            end
        endcase
    end

    // --------------------------------------------------------------------
    // memories: reads are issued on accept, written back in the update cycle.
    // one item is in flight, so a read never meets a pending write to the
    // same entry and no forwarding is needed
    // --------------------------------------------------------------------
    assign stack_raddr = IDX_W'(r_free_top - CNT_W'(1)); // top of stack entry

    sas_ram #(
        .WIDTH (sas_pkg::PAYLOAD_BITS),
        .DEPTH (sas_pkg::SLOTS)
    ) u_slot_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (r_req.payload),
        .i_re    (accept),
        .i_raddr (i_req.slot_index),
        .o_rdata (store_rdata)
    );

    sas_ram #(
        .WIDTH (IDX_W),
        .DEPTH (sas_pkg::SLOTS)
    ) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (IDX_W'(r_free_top)),
        .i_wdata (r_req.slot_index),
        .i_re    (accept),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

    // --------------------------------------------------------------------
    // update cycle decode
    // --------------------------------------------------------------------
    always_comb begin
        stack_nonempty = (r_free_top != '0);
        add_got        = 1'b0;
        add_slot       = '0;
        // most recently freed slot wins, else the fresh slot at the high-water mark
        if (stack_nonempty) begin
            add_got  = 1'b1;
            add_slot = stack_rdata;
        end else if (r_high_water < SLOT_LIMIT) begin
            add_got  = 1'b1;
            add_slot = IDX_W'(r_high_water);
        end
        // remove only a slot that was handed out and is still live
        remove_ok = ({1'b0, r_req.slot_index} < r_high_water)
                    && r_occupied[r_req.slot_index];
    end

    always_comb begin
        store_we    = 1'b0;
        store_waddr = add_slot;
        stack_we    = 1'b0;
        n_free_top   = r_free_top;
        n_high_water = r_high_water;
        n_occ_total  = r_occ_total;
        n_occupied   = r_occupied;
        n_res        = r_res;
        if (r_state == sas_pkg::ST_EXEC) begin
            n_res.assigned_index   = '0;
            n_res.released_payload = '0;
            if (r_req.req_type == sas_pkg::REQ_ADD) begin
                if (add_got) begin
                    store_we             = 1'b1;
                    n_occupied[add_slot] = 1'b1;
                    n_occ_total          = r_occ_total + CNT_W'(1);
                    n_res.assigned_index = add_slot;
                    n_res.status         = sas_pkg::STAT_ADDED;
                    if (stack_nonempty) begin
                        n_free_top = r_free_top - CNT_W'(1);
                    end else begin
                        n_high_water = r_high_water + CNT_W'(1);
                    end
                end else begin
                    n_res.status = sas_pkg::STAT_FULL;
                end
            end else begin
                if (remove_ok) begin
                    n_occupied[r_req.slot_index] = 1'b0;
                    n_res.released_payload       = store_rdata;
                    n_res.status                 = sas_pkg::STAT_REMOVED;
                    if (r_occ_total != '0) begin
                        n_occ_total = r_occ_total - CNT_W'(1);
                    end
                    // push the freed index; depth cannot pass the slot count
                    if (r_free_top < SLOT_LIMIT) begin
                        stack_we   = 1'b1;
                        n_free_top = r_free_top + CNT_W'(1);
                    end
                end else begin
                    n_res.status = sas_pkg::STAT_IGNORED;
                end
            end
            n_res.live_count = n_occ_total;
        end
    end

    // --------------------------------------------------------------------
    // registers
    // --------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sas_pkg::ST_IDLE;
            r_free_top   <= '0;
            r_high_water <= '0;
            r_occ_total  <= '0;
            r_occupied   <= '0;
        end else begin
            r_state      <= n_state;
            r_free_top   <= n_free_top;
            r_high_water <= n_high_water;
            r_occ_total  <= n_occ_total;
            r_occupied   <= n_occupied;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        r_res <= n_res;
    end

    assign o_res = r_res;

    // --------------------------------------------------------------------
    // assertions
    // --------------------------------------------------------------------
    // every handed-out slot is either live or on the free stack
    `SAS_ASSERT_IMP(a_slot_balance, i_clk, i_rst_n, 1'b1,
        (r_free_top + r_occ_total) == r_high_water)
    // live count tracks the occupancy bits
    `SAS_ASSERT_IMP(a_count_matches, i_clk, i_rst_n, 1'b1,
        $countones(r_occupied) == int'(r_occ_total))
    // an update cycle is always followed by a held result
    `SAS_ASSERT_NXT(a_exec_to_out, i_clk, i_rst_n, r_state == sas_pkg::ST_EXEC,
        o_res_valid)
    // an added slot is marked live while its result is shown
    `SAS_ASSERT_IMP(a_added_live, i_clk, i_rst_n,
        o_res_valid && (o_res.status == sas_pkg::STAT_ADDED),
        r_occupied[o_res.assigned_index])

endmodule

/* hw/rtl/sas_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/sv/tb_slot_allocator_free_stack.sv */
// self-checking testbench for the lifo free-list slot allocator
// depends on sas_pkg for the item types and codes, and on slot_allocator_free_stack
module tb_slot_allocator_free_stack;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD_BITS = sas_pkg::PAYLOAD_BITS;
    localparam int SLOTS        = sas_pkg::SLOTS;
    localparam int IDX_W        = sas_pkg::IDX_W;
    localparam int CNT_W        = sas_pkg::CNT_W;

    // run shape
    localparam int RAND_ITEMS     = 1450;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_START     = 600;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_GUARD    = 8;
    localparam int MAX_SHOWN      = 10;

    // traffic mixes for the random part
    typedef enum int {
        PH_FILL,
        PH_GROW,
        PH_SHRINK,
        PH_CHURN,
        PH_NOISE
    } t_phase;

    // one row of the directed part; want only counts when pinned is set
    typedef struct {
        sas_pkg::t_req_item rq;
        bit                 pinned;
        sas_pkg::t_res_item want;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_req_valid;
    logic               o_req_stall;
    sas_pkg::t_req_item i_req;
    logic               o_res_valid;
    logic               i_res_stall;
    sas_pkg::t_res_item o_res;

    // shadow of the allocator, advanced in issue order by the sender
    logic [PAYLOAD_BITS-1:0] held_payload [SLOTS];
    logic                    held_used    [SLOTS];
    logic [IDX_W-1:0]        freed_slots  [SLOTS];
    logic [CNT_W-1:0]        freed_depth;
    logic [CNT_W-1:0]        high_mark;
    logic [CNT_W-1:0]        live_slots;

    // results still owed by the block, oldest first
    sas_pkg::t_res_item expected_results [$];
    t_dir_row           dir_rows [$];

    int mismatches  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;

    slot_allocator_free_stack dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicts the result of one request and moves the shadow state on
    function automatic sas_pkg::t_res_item predict_slot_result(input sas_pkg::t_req_item rq);
        sas_pkg::t_res_item res;
        logic [IDX_W-1:0]   slot;
        bit                 got;
        res  = '0;
        slot = '0;
        got  = 1'b0;
        if (rq.req_type == sas_pkg::REQ_ADD) begin
            // most recently freed slot first, then fresh slots from the high-water mark
            if (freed_depth != '0) begin
                freed_depth = freed_depth - CNT_W'(1);
                slot        = freed_slots[freed_depth];
                got         = 1'b1;
            end else if (high_mark < CNT_W'(SLOTS)) begin
                slot      = high_mark[IDX_W-1:0];
                high_mark = high_mark + CNT_W'(1);
                got       = 1'b1;
            end
            if (got) begin
                held_payload[slot] = rq.payload;
                held_used[slot]    = 1'b1;
                live_slots         = live_slots + CNT_W'(1);
                res.assigned_index = slot;
                res.status         = sas_pkg::STAT_ADDED;
            end else begin
                // table full: nothing stored, nothing changes
                res.status = sas_pkg::STAT_FULL;
            end
        end else if ({1'b0, rq.slot_index} < high_mark && held_used[rq.slot_index]) begin
            res.released_payload     = held_payload[rq.slot_index];
            held_used[rq.slot_index] = 1'b0;
            live_slots               = live_slots - CNT_W'(1);
            freed_slots[freed_depth] = rq.slot_index;
            freed_depth              = freed_depth + CNT_W'(1);
            res.status               = sas_pkg::STAT_REMOVED;
        end else begin
            // empty slot, or at or above the high-water mark
            res.status = sas_pkg::STAT_IGNORED;
        end
        res.live_count = live_slots;
        return res;
    endfunction

    // random request; aimed removes mostly name a slot that is occupied right now
    function automatic sas_pkg::t_req_item random_request(input int add_pct, input bit aimed);
        sas_pkg::t_req_item rq;
        int                 k;
        rq.req_type   = ($urandom_range(0, 99) < add_pct) ? sas_pkg::REQ_ADD
                                                          : sas_pkg::REQ_REMOVE;
        rq.slot_index = IDX_W'($urandom_range(0, SLOTS - 1));
        case ($urandom_range(0, 9))
            0:       rq.payload = '0;
            1:       rq.payload = '1;
            default: rq.payload = PAYLOAD_BITS'($urandom());
        endcase
        if (rq.req_type == sas_pkg::REQ_REMOVE && aimed && live_slots != '0
                && $urandom_range(0, 9) != 0) begin
            k = $urandom_range(0, int'(live_slots) - 1);
            for (int s = 0; s < SLOTS; s++) begin
                if (held_used[s]) begin
                    if (k == 0) begin
                        rq.slot_index = IDX_W'(s);
                        break;
                    end
                    k--;
                end
            end
        end
        return rq;
    endfunction

    task automatic dir_row(input logic op, input logic [PAYLOAD_BITS-1:0] pl,
                           input logic [IDX_W-1:0] idx, input bit pin,
                           input logic [IDX_W-1:0] ai, input logic [1:0] st,
                           input logic [PAYLOAD_BITS-1:0] rel,
                           input logic [CNT_W-1:0] cnt);
        t_dir_row row;
        row.rq.req_type           = op;
        row.rq.payload            = pl;
        row.rq.slot_index         = idx;
        row.pinned                = pin;
        row.want.assigned_index   = ai;
        row.want.status           = st;
        row.want.released_payload = rel;
        row.want.live_count       = cnt;
        dir_rows.push_back(row);
    endtask

    // offers one item in the sender's burst pattern and returns once it is taken
    task automatic offer(input sas_pkg::t_req_item rq, input bit pin,
                         input sas_pkg::t_res_item typed);
        sas_pkg::t_res_item predicted;
        int                 gap;
        // items are taken strictly in order, so predicting at issue is exact
        predicted = predict_slot_result(rq);
        expected_results.push_back(pin ? typed : predicted);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_req       <= rq;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (o_req_stall);
    endtask

    // holds the sender back until every owed result is in; queue read off the falling edge
    task automatic wait_for_results();
        i_req_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic report_mismatch(input string what, input sas_pkg::t_res_item want,
                                   input sas_pkg::t_res_item got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%s: expected idx %0d st %0d rel %h cnt %0d, got idx %0d st %0d rel %h cnt %0d",
                     what, want.assigned_index, want.status, want.released_payload,
                     want.live_count, got.assigned_index, got.status,
                     got.released_payload, got.live_count);
    endtask

    // result side: checks every taken result and watches for lack of progress
    always @(posedge i_clk) begin : result_check
        sas_pkg::t_res_item want;
        bit                 progress;
        if (i_rst_n) begin
            progress = (i_req_valid && !o_req_stall);
            if (o_res_valid && !i_res_stall) begin
                progress = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing owed", '0, o_res);
                end else begin
                    want = expected_results.pop_front();
                    if (o_res.assigned_index !== want.assigned_index
                            || o_res.status !== want.status
                            || o_res.released_payload !== want.released_payload
                            || o_res.live_count !== want.live_count)
                        report_mismatch("result mismatch", want, o_res);
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_slot_allocator_free_stack: done, errors");
                $finish;
            end
        end
    end

    // receiver stall pattern, with one long hold-off so the block backs up
    initial begin : res_stall_pattern
        int cyc;
        int pct;
        cyc         = 0;
        pct         = 0;
        i_res_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 64 == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    pct = 0;
                    2:       pct = 25;
                    3:       pct = 60;
                    default: pct = 90;
                endcase
            end
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
                i_res_stall <= 1'b1;
            else
                i_res_stall <= ($urandom_range(0, 99) < pct);
        end
    end

    initial begin : stimulus
        t_phase             kind;
        int                 made;
        int                 count;
        int                 add_pct;
        bit                 drained_once;
        sas_pkg::t_res_item none;
        none         = '0;
        made         = 0;
        drained_once = 1'b0;
        i_rst_n      = 1'b0;
        i_req_valid  = 1'b0;
        i_req        = '0;
        foreach (held_used[s]) begin
            held_used[s]    = 1'b0;
            held_payload[s] = '0;
            freed_slots[s]  = '0;
        end
        freed_depth = '0;
        high_mark   = '0;
        live_slots  = '0;

        // directed: removes on an empty table, extreme payloads and indices,
        // removes at and above the high-water mark, double remove, lifo reuse
        dir_row(sas_pkg::REQ_REMOVE, '0, 6'd0, 1'b1, 6'd0, sas_pkg::STAT_IGNORED, '0, 7'd0);
        dir_row(sas_pkg::REQ_REMOVE, '1, 6'd63, 1'b1, 6'd0, sas_pkg::STAT_IGNORED, '0, 7'd0);
        dir_row(sas_pkg::REQ_ADD, 32'h0000_0000, 6'd63, 1'b1, 6'd0, sas_pkg::STAT_ADDED,
                '0, 7'd1);
        dir_row(sas_pkg::REQ_ADD, 32'hffff_ffff, 6'd0, 1'b1, 6'd1, sas_pkg::STAT_ADDED,
                '0, 7'd2);
        dir_row(sas_pkg::REQ_ADD, 32'ha5a5_a5a5, 6'd21, 1'b1, 6'd2, sas_pkg::STAT_ADDED,
                '0, 7'd3);
        dir_row(sas_pkg::REQ_ADD, 32'h5a5a_5a5a, 6'd42, 1'b1, 6'd3, sas_pkg::STAT_ADDED,
                '0, 7'd4);
        dir_row(sas_pkg::REQ_REMOVE, '0, 6'd63, 1'b1, 6'd0, sas_pkg::STAT_IGNORED, '0, 7'd4);
        dir_row(sas_pkg::REQ_REMOVE, '0, 6'd4, 1'b1, 6'd0, sas_pkg::STAT_IGNORED, '0, 7'd4);
        dir_row(sas_pkg::REQ_REMOVE, '1, 6'd1, 1'b1, 6'd0, sas_pkg::STAT_REMOVED,
                32'hffff_ffff, 7'd3);
        dir_row(sas_pkg::REQ_REMOVE, '0, 6'd1, 1'b1, 6'd0, sas_pkg::STAT_IGNORED, '0, 7'd3);
        dir_row(sas_pkg::REQ_REMOVE, '0, 6'd3, 1'b1, 6'd0, sas_pkg::STAT_REMOVED,
                32'h5a5a_5a5a, 7'd2);
        dir_row(sas_pkg::REQ_REMOVE, '0, 6'd0, 1'b1, 6'd0, sas_pkg::STAT_REMOVED,
                32'h0000_0000, 7'd1);
        dir_row(sas_pkg::REQ_ADD, 32'h1234_5678, 6'd0, 1'b1, 6'd0, sas_pkg::STAT_ADDED,
                '0, 7'd2);
        dir_row(sas_pkg::REQ_ADD, 32'h8000_0000, 6'd0, 1'b1, 6'd3, sas_pkg::STAT_ADDED,
                '0, 7'd3);
        dir_row(sas_pkg::REQ_ADD, 32'h0000_0001, 6'd0, 1'b1, 6'd1, sas_pkg::STAT_ADDED,
                '0, 7'd4);
        dir_row(sas_pkg::REQ_ADD, 32'hdead_beef, 6'd0, 1'b1, 6'd4, sas_pkg::STAT_ADDED,
                '0, 7'd5);
        dir_row(sas_pkg::REQ_REMOVE, '0, 6'd2, 1'b1, 6'd0, sas_pkg::STAT_REMOVED,
                32'ha5a5_a5a5, 7'd4);
        dir_row(sas_pkg::REQ_REMOVE, '0, 6'd4, 1'b1, 6'd0, sas_pkg::STAT_REMOVED,
                32'hdead_beef, 7'd3);
        dir_row(sas_pkg::REQ_REMOVE, '0, 6'd0, 1'b1, 6'd0, sas_pkg::STAT_REMOVED,
                32'h1234_5678, 7'd2);
        dir_row(sas_pkg::REQ_REMOVE, '0, 6'd3, 1'b1, 6'd0, sas_pkg::STAT_REMOVED,
                32'h8000_0000, 7'd1);
        dir_row(sas_pkg::REQ_REMOVE, '0, 6'd1, 1'b1, 6'd0, sas_pkg::STAT_REMOVED,
                32'h0000_0001, 7'd0);
        // deeper lifo order, left to the predictor
        dir_row(sas_pkg::REQ_ADD, 32'hcafe_f00d, 6'd9, 1'b0, '0, sas_pkg::STAT_ADDED, '0, '0);
        dir_row(sas_pkg::REQ_ADD, 32'h0bad_f00d, 6'd9, 1'b0, '0, sas_pkg::STAT_ADDED, '0, '0);
        dir_row(sas_pkg::REQ_REMOVE, '0, 6'd1, 1'b0, '0, sas_pkg::STAT_ADDED, '0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            offer(dir_rows[r].rq, dir_rows[r].pinned, dir_rows[r].want);

        // random part: phases of differing add/remove mix, including runs to full
        while (made < RAND_ITEMS) begin
            kind = t_phase'($urandom_range(0, 4));
            if (kind == PH_FILL) begin
                // fill every slot, then a few adds that must come back full
                count = SLOTS - int'(live_slots) + int'($urandom_range(1, 3));
                repeat (count) offer(random_request(100, 1'b1), 1'b0, none);
            end else begin
                count = $urandom_range(20, 120);
                case (kind)
                    PH_GROW:   add_pct = 75;
                    PH_SHRINK: add_pct = 25;
                    default:   add_pct = 50;
                endcase
                // noise phases aim removes anywhere, including empty and unreached slots
                repeat (count) offer(random_request(add_pct, kind != PH_NOISE), 1'b0, none);
            end
            made += count;
            if (!drained_once && made >= RAND_ITEMS / 2) begin
                // sender pauses until the block has handed back everything
                wait_for_results();
                drained_once = 1'b1;
            end
        end

        wait_for_results();
        repeat (DRAIN_GUARD) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_slot_allocator_free_stack: done, clean");
        else
            $display("tb_slot_allocator_free_stack: done, errors");
        $finish;
    end

endmodule
